>>> rtl/apn_pkg.sv
// ----------------------------------------------------------------------------
// apn_pkg: shared types and constants for the path normalizer
// Byte codes, buffer and stack geometry, and the structs between modules.
// ----------------------------------------------------------------------------
package apn_pkg;

    localparam logic [7:0] SLASH       = 8'h2F;
    localparam logic [7:0] DOT         = 8'h2E;

    localparam int         BUF_DEPTH   = 64;
    localparam int         BUF_AW      = 6;
    localparam int         STACK_DEPTH = 32;
    localparam int         STACK_AW    = 5;
    localparam int         CNT_W       = 7;

    typedef logic [7:0]        byte_t;
    typedef logic [BUF_AW-1:0] buf_addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // one write into the line buffer
    typedef struct packed {
        logic      en;
        buf_addr_t addr;
        byte_t     data;
    } buf_wr_t;

    // end of run: status and number of bytes to emit (zero means bare root)
    typedef struct packed {
        logic done;
        logic err;
        cnt_t len;
    } run_done_t;

endpackage

>>> rtl/apn_in_if.sv
// ----------------------------------------------------------------------------
// apn_in_if: input path byte channel
// Valid/ready channel carrying one path byte and its last marker.
// ----------------------------------------------------------------------------
interface apn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

>>> rtl/apn_out_if.sv
// ----------------------------------------------------------------------------
// apn_out_if: normalized path result channel
// Valid/ready channel carrying one result byte, last marker and error flag.
// ----------------------------------------------------------------------------
interface apn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_ch;
    logic       out_last;
    logic       error;

    modport source (output valid, output out_ch, output out_last, output error, input ready);
    modport sink   (input valid, input out_ch, input out_last, input error, output ready);
endinterface

>>> rtl/absolute_path_normalizer.sv
// Result path: the end of a run sets the busy register; an error result then goes
//   straight into the output register, a path byte only after a line buffer read.
// Throughput: one input byte per cycle while parsing; the path is read out of the
//   line buffer with one read in flight at a time; input stalls during readout.
// Reset: rst_n asynchronously clears the parser state and the busy, pending and
//   valid flags; buffer and stack contents are kept, always written before read.
// ----------------------------------------------------------------------------
// absolute_path_normalizer: lexical cleaner for absolute paths
// Collapses repeated slashes, drops "." and resolves ".." against a stack of
// component starts, then streams the cleaned path out with a last marker.
// ----------------------------------------------------------------------------
module absolute_path_normalizer #(
    parameter int PATH_MAX = 64     // 8 .. 64; results must stay below this
)
(
    input  logic      clk,
    input  logic      rst_n,
    apn_in_if.sink    path,
    apn_out_if.source clean
);
    import apn_pkg::*;

    buf_wr_t   wr;
    run_done_t done;
    logic      busy;
    logic      take;
    logic      rd_en;
    buf_addr_t rd_addr;
    byte_t     rd_data;

    // Input is taken whenever no finished path is being read out. The parser
    // itself keeps up with one byte a cycle; every decision for a byte
    // (separator, name byte, component judgement, stack pop) settles in the
    // same cycle.
    assign path.ready = !busy;
    assign take       = path.valid && path.ready;

    apn_ctrl #(
        .PATH_MAX (PATH_MAX)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .ch    (path.ch),
        .last  (path.last),
        .wr    (wr),
        .done  (done)
    );

    // Name bytes are written speculatively after the committed bytes; a
    // dropped component is simply overwritten later.
    apn_linebuf u_linebuf (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Readout: one buffer read in flight at a time; each result passes through the
    // buffer read register before it lands in the output register.
    apn_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .done      (done),
        .rd_data   (rd_data),
        .out_ready (clean.ready),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .out_valid (clean.valid),
        .out_ch    (clean.out_ch),
        .out_last  (clean.out_last),
        .out_error (clean.error)
    );

endmodule

>>> rtl/apn_linebuf.sv
// ----------------------------------------------------------------------------
// apn_linebuf: line buffer memory
// 64 x 8 single write port, single registered read port.
// ----------------------------------------------------------------------------
module apn_linebuf
(
    input  logic               clk,
    input  apn_pkg::buf_wr_t   wr,
    input  logic               rd_en,
    input  apn_pkg::buf_addr_t rd_addr,
    output apn_pkg::byte_t     rd_data
);
    import apn_pkg::*;

    byte_t mem [BUF_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/apn_ctrl.sv
// ----------------------------------------------------------------------------
// apn_ctrl: per-byte path parser
// Tracks the pending component, the committed length and the component
// start stack; issues line buffer writes and reports the end of each run.
// ----------------------------------------------------------------------------
module apn_ctrl #(
    parameter int PATH_MAX = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  apn_pkg::byte_t      ch,
    input  logic                last,
    output apn_pkg::buf_wr_t    wr,
    output apn_pkg::run_done_t  done
);
    import apn_pkg::*;

    localparam cnt_t       PMAX   = cnt_t'(PATH_MAX);
    localparam logic [7:0] PMAX8  = 8'(PATH_MAX);

    cnt_t                 wc_reg, wc_next;
    logic [STACK_AW:0]    sd_reg, sd_next;
    cnt_t                 cl_reg, cl_next;
    logic                 cd_reg, cd_next;
    logic                 err_reg, err_next;
    logic                 first_reg, first_next;
    logic                 ls_reg, ls_next;      // last committed byte is '/'
    buf_addr_t            stack_reg [STACK_DEPTH];

    logic                 is_slash, is_dot;
    logic                 do_slash, do_name, fin;
    logic                 push_en;
    cnt_t                 fin_len;
    logic                 fin_dots;
    logic [7:0]           pos;
    logic [7:0]           sum_len;
    logic [STACK_AW-1:0]  top_idx;
    cnt_t                 n;

    assign is_slash = (ch == SLASH);
    assign is_dot   = (ch == DOT);
    assign pos      = {1'b0, wc_reg} + {1'b0, cl_reg};
    assign top_idx  = sd_reg[STACK_AW-1:0] - 1'b1;
    assign sum_len  = {1'b0, wc_reg} + {1'b0, fin_len};

    always_comb
    begin
        wc_next    = wc_reg;
        sd_next    = sd_reg;
        cl_next    = cl_reg;
        cd_next    = cd_reg;
        err_next   = err_reg;
        first_next = first_reg;
        ls_next    = ls_reg;
        push_en    = 1'b0;
        wr         = '0;
        done       = '0;
        do_slash   = 1'b0;
        do_name    = 1'b0;
        n          = '0;

        if (take && !err_reg)
        begin
            if (!first_reg)
            begin
                first_next = 1'b1;
                if (!is_slash)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    do_slash = 1'b1;
                end
            end
            else if (is_slash)
            begin
                do_slash = 1'b1;
            end
            else
            begin
                do_name = 1'b1;
            end
        end

        // name byte goes after the committed bytes while it fits
        if (do_name)
        begin
            if (pos < PMAX8)
            begin
                wr.en   = 1'b1;
                wr.addr = pos[BUF_AW-1:0];
                wr.data = ch;
            end
            cd_next = (cl_reg == '0) ? is_dot : (cd_reg & is_dot);
            if (cl_reg < PMAX)
            begin
                cl_next = cl_reg + 1'b1;
            end
        end

        // judge the pending component
        fin      = do_slash || (do_name && last);
        fin_len  = do_slash ? cl_reg : cl_next;
        fin_dots = do_slash ? cd_reg : cd_next;
        if (fin)
        begin
            if (fin_len == '0 || (fin_dots && fin_len == cnt_t'(1)))
            begin
                // empty or "." : nothing to do
                wc_next = wc_reg;
            end
            else if (fin_dots && fin_len == cnt_t'(2))
            begin
                if (sd_reg != '0)
                begin
                    sd_next = sd_reg - 1'b1;
                    wc_next = {1'b0, stack_reg[top_idx]};
                    ls_next = 1'b1;
                end
            end
            else if (sum_len >= PMAX8)
            begin
                err_next = 1'b1;
            end
            else
            begin
                push_en = (sd_reg < (STACK_AW+1)'(STACK_DEPTH));
                if (push_en)
                begin
                    sd_next = sd_reg + 1'b1;
                end
                wc_next = sum_len[CNT_W-1:0];
                ls_next = 1'b0;
            end
            cl_next = '0;
            cd_next = 1'b0;
        end

        // separator, unless one is already last
        if (do_slash && !err_next)
        begin
            if (wc_next == '0 || !ls_next)
            begin
                if (wc_next >= PMAX - 1'b1)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    wr.en   = 1'b1;
                    wr.addr = wc_next[BUF_AW-1:0];
                    wr.data = SLASH;
                    wc_next = wc_next + 1'b1;
                    ls_next = 1'b1;
                end
            end
        end

        // end of run: report, then back to the idle run state
        if (take && last)
        begin
            n = wc_next;
            if (n > cnt_t'(1) && ls_next)
            begin
                n = n - 1'b1;
            end
            done.done  = 1'b1;
            done.err   = err_next;
            done.len   = n;
            wc_next    = '0;
            sd_next    = '0;
            cl_next    = '0;
            cd_next    = 1'b0;
            err_next   = 1'b0;
            first_next = 1'b0;
            ls_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg    <= '0;
            sd_reg    <= '0;
            cl_reg    <= '0;
            cd_reg    <= 1'b0;
            err_reg   <= 1'b0;
            first_reg <= 1'b0;
            ls_reg    <= 1'b0;
        end
        else
        begin
            wc_reg    <= wc_next;
            sd_reg    <= sd_next;
            cl_reg    <= cl_next;
            cd_reg    <= cd_next;
            err_reg   <= err_next;
            first_reg <= first_next;
            ls_reg    <= ls_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_reg[sd_reg[STACK_AW-1:0]] <= wc_reg[BUF_AW-1:0];
        end
    end

endmodule

>>> rtl/apn_emit.sv
// ----------------------------------------------------------------------------
// apn_emit: result sequencer
// Reads the finished path out of the line buffer into the output register,
// or places the single error result.
// ----------------------------------------------------------------------------
module apn_emit
(
    input  logic                clk,
    input  logic                rst_n,
    input  apn_pkg::run_done_t  done,
    input  apn_pkg::byte_t      rd_data,
    input  logic                out_ready,
    output logic                busy,
    output logic                rd_en,
    output apn_pkg::buf_addr_t  rd_addr,
    output logic                out_valid,
    output apn_pkg::byte_t      out_ch,
    output logic                out_last,
    output logic                out_error
);
    import apn_pkg::*;

    logic  busy_reg, busy_next;
    logic  errm_reg, errm_next;
    logic  root_reg, root_next;
    cnt_t  n_reg, n_next;
    cnt_t  cnt_reg, cnt_next;
    logic  pend_reg, pend_next;
    logic  plast_reg, plast_next;
    logic  ov_reg, ov_next;
    byte_t och_reg, och_next;
    logic  olast_reg, olast_next;
    logic  oerr_reg, oerr_next;

    logic  free, issue, final_rd;
    cnt_t  cnt_inc;

    assign free     = !ov_reg || out_ready;
    assign issue    = busy_reg && !pend_reg && free;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign final_rd = (cnt_inc == n_reg);
    assign rd_addr  = cnt_reg[BUF_AW-1:0];

    always_comb
    begin
        busy_next  = busy_reg;
        errm_next  = errm_reg;
        root_next  = root_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        plast_next = plast_reg;
        ov_next    = ov_reg && !out_ready;
        och_next   = och_reg;
        olast_next = olast_reg;
        oerr_next  = oerr_reg;
        rd_en      = 1'b0;

        // read data of last cycle lands in the output register
        if (pend_reg)
        begin
            ov_next    = 1'b1;
            och_next   = root_reg ? SLASH : rd_data;
            olast_next = plast_reg;
            oerr_next  = 1'b0;
            pend_next  = 1'b0;
        end

        if (issue)
        begin
            if (errm_reg)
            begin
                ov_next    = 1'b1;
                och_next   = '0;
                olast_next = 1'b1;
                oerr_next  = 1'b1;
                busy_next  = 1'b0;
            end
            else
            begin
                rd_en      = 1'b1;
                pend_next  = 1'b1;
                plast_next = final_rd;
                cnt_next   = cnt_inc;
                if (final_rd)
                begin
                    busy_next = 1'b0;
                end
            end
        end

        if (done.done)
        begin
            busy_next = 1'b1;
            errm_next = done.err;
            root_next = (done.len == '0);
            n_next    = (done.len == '0) ? cnt_t'(1) : done.len;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        errm_reg  <= errm_next;
        root_reg  <= root_next;
        n_reg     <= n_next;
        cnt_reg   <= cnt_next;
        plast_reg <= plast_next;
        och_reg   <= och_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    assign busy      = busy_reg;
    assign out_valid = ov_reg;
    assign out_ch    = och_reg;
    assign out_last  = olast_reg;
    assign out_error = oerr_reg;

endmodule

>>> rtl/apn_checker.sv
// ----------------------------------------------------------------------------
// apn_checker: port-level checks for the path normalizer
// Watches both channels and flags handshake and result-format slips.
// ----------------------------------------------------------------------------
module apn_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_ch,
    input logic       out_last,
    input logic       out_error
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

    // and keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_ch) && $stable(out_last) && $stable(out_error))
    else $error("stalled result changed");

    // error result is alone: zero byte, ends the run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_error |-> out_last && (out_ch == 8'h00))
    else $error("malformed error result");

    // the end of a run blocks input until its results are under way
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after end of run");

endmodule

bind absolute_path_normalizer apn_checker u_apn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (path.valid),
    .in_ready  (path.ready),
    .in_last   (path.last),
    .out_valid (clean.valid),
    .out_ready (clean.ready),
    .out_ch    (clean.out_ch),
    .out_last  (clean.out_last),
    .out_error (clean.error)
);

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the absolute path normalizer
// Feeds whole paths a byte per item, predicts cleaned bytes in a local model
// of the block or takes them from literal rows, and checks results in order.
// ----------------------------------------------------------------------------
module tb;

    import apn_pkg::*;

    localparam int PMAX     = 64;    // path limit the block is built with
    localparam int WATCHDOG = 2000;  // cycles with no item moving on either side
    localparam int SETTLE   = 16;    // quiet cycles after the last result
    localparam int RAND_ITEMS = 120;

    // how a directed row is checked
    typedef enum int {BY_PREDICTOR, LITERAL_PATH, LITERAL_ERROR} check_t;

    // receiver behavior for one stretch of cycles
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT, RX_HOLD} rx_mode_t;

    typedef struct {
        string  text;   // '#' stands for byte 00, '%' for byte ff
        string  want;
        check_t kind;
    } dir_row_t;

    typedef struct {
        byte_t ch;
        logic  last;
        int    row;        // directed row index, -1 for random paths
        bit    drain_after; // sender waits for all results after this item
    } path_item_t;

    typedef struct packed {
        byte_t ch;
        logic  last;
        logic  err;
    } clean_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    apn_in_if  path_if ();
    apn_out_if clean_if ();

    absolute_path_normalizer #(.PATH_MAX(PMAX)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .path  (path_if),
        .clean (clean_if)
    );

    always #2 clk = ~clk;

    dir_row_t    dir_rows [$];
    path_item_t  path_items [$];
    clean_item_t due_bytes [$];     // cleaned bytes still to come, oldest first
    clean_item_t norm_result [$];   // what the last finished path produced
    int          accept_idx = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;

    // ------------------------------------------------------------------------
    // Local model of the normalizer: line buffer plus a stack of the start
    // offsets of kept components, so ".." rewinds the buffer in one step.
    // ------------------------------------------------------------------------
    byte_t nb_buf [BUF_DEPTH];
    int    nb_starts [STACK_DEPTH];
    int    nb_len      = 0;   // committed bytes in nb_buf
    int    nb_depth    = 0;
    int    nb_comp_len = 0;   // pending component, saturating at PMAX
    bit    nb_comp_dots = 1'b0;
    bit    nb_failed   = 1'b0;
    bit    nb_started  = 1'b0;

    // judge the pending component once a slash or the last byte ends it
    function automatic void norm_close_component();
        if (nb_comp_len == 0)
            return;
        if (nb_comp_dots && nb_comp_len == 2) begin
            // ".." pops one level; at root there is nothing to pop
            if (nb_depth > 0) begin
                nb_depth--;
                nb_len = nb_starts[nb_depth];
            end
        end
        else if (!(nb_comp_dots && nb_comp_len == 1)) begin
            if (nb_len + nb_comp_len >= PMAX)
                nb_failed = 1'b1;
            else begin
                if (nb_depth < STACK_DEPTH) begin
                    nb_starts[nb_depth] = nb_len;
                    nb_depth++;
                end
                nb_len += nb_comp_len;
            end
        end
        nb_comp_len  = 0;
        nb_comp_dots = 1'b0;
    endfunction

    function automatic void norm_put_slash();
        norm_close_component();
        if (nb_failed)
            return;
        if (nb_len == 0 || nb_buf[nb_len - 1] != SLASH) begin
            // a slash that would land on the last free slot fails the path,
            // even if it would be stripped as trailing later on
            if (nb_len >= PMAX - 1) begin
                nb_failed = 1'b1;
                return;
            end
            nb_buf[nb_len] = SLASH;
            nb_len++;
        end
    endfunction

    // take one accepted byte; on the last one, fill norm_result
    function automatic void norm_step(byte_t c, logic last);
        int pos;
        int n;
        norm_result.delete();
        if (!nb_failed) begin
            if (!nb_started) begin
                nb_started = 1'b1;
                if (c != SLASH)
                    nb_failed = 1'b1;
                else
                    norm_put_slash();
            end
            else if (c == SLASH)
                norm_put_slash();
            else begin
                pos = nb_len + nb_comp_len;
                if (pos < PMAX)
                    nb_buf[pos] = c;
                if (nb_comp_len == 0)
                    nb_comp_dots = (c == DOT);
                else
                    nb_comp_dots = nb_comp_dots && (c == DOT);
                if (nb_comp_len < PMAX)
                    nb_comp_len++;
            end
        end
        if (!last)
            return;
        if (!nb_failed)
            norm_close_component();
        if (nb_failed)
            norm_result.push_back('{8'h00, 1'b1, 1'b1});
        else begin
            n = nb_len;
            if (n > 1 && nb_buf[n - 1] == SLASH)
                n--;
            if (n == 0) begin
                nb_buf[0] = SLASH;
                n = 1;
            end
            for (int k = 0; k < n; k++)
                norm_result.push_back('{nb_buf[k], (k == n - 1), 1'b0});
        end
        nb_len       = 0;
        nb_depth     = 0;
        nb_comp_len  = 0;
        nb_comp_dots = 1'b0;
        nb_failed    = 1'b0;
        nb_started   = 1'b0;
    endfunction

    function automatic string repeat_char(string s, int n);
        string r;
        r = "";
        for (int i = 0; i < n; i++)
            r = {r, s};
        return r;
    endfunction

    function automatic void queue_path(byte_t bytes [$], int row, bit drain);
        for (int i = 0; i < bytes.size(); i++)
            path_items.push_back('{bytes[i], (i == bytes.size() - 1), row,
                                   drain && (i == bytes.size() - 1)});
    endfunction

    function automatic byte_t name_byte();
        byte_t b;
        if ($urandom_range(0, 1) == 0)
            b = 8'h61 + byte_t'($urandom_range(0, 25));
        else
            b = byte_t'($urandom_range(0, 255));
        if (b == SLASH)
            b = 8'h2D;
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus build, reset and the path sender.
    // The sender runs in bursts with random gaps; it stops twice and waits for
    // every result to drain (after the directed rows, and midway through the
    // random paths).
    // ------------------------------------------------------------------------
    initial begin : path_sender
        byte_t draft [$];
        int    rand_count;
        int    ncomp;
        int    pick;
        int    len;
        int    idx;
        int    burst;
        int    gap;
        bit    mid_drain_done;

        path_if.valid <= 1'b0;
        path_if.ch    <= '0;
        path_if.last  <= 1'b0;

        // directed rows: plain cases, the dot rules, byte extremes, both
        // overflow kinds and a deep component stack unwound past root
        dir_rows = '{
            '{"/",                 "/",    LITERAL_PATH},
            '{"x",                 "",     LITERAL_ERROR},
            '{"a/b/c",             "",     LITERAL_ERROR},
            '{"//",                "/",    LITERAL_PATH},
            '{"///a///",           "/a",   LITERAL_PATH},
            '{"/.",                "/",    LITERAL_PATH},
            '{"/..",               "/",    LITERAL_PATH},
            '{"/../../x",          "/x",   LITERAL_PATH},
            '{"/...",              "/...", LITERAL_PATH},
            '{"/a/..",             "/",    LITERAL_PATH},
            '{"/a/./b/../c/",      "",     BY_PREDICTOR},
            '{"/a/b/c/../../d/.",  "",     BY_PREDICTOR},
            '{"/.a/..b/a./..../.", "",     BY_PREDICTOR},
            '{"/#/%/#%",           "",     BY_PREDICTOR},
            '{{"/", repeat_char("a", 62)},            "", BY_PREDICTOR},
            '{{"/", repeat_char("a", 62), "/"},       "", LITERAL_ERROR},
            '{{"/", repeat_char("a", 63)},            "", LITERAL_ERROR},
            '{{"/", repeat_char("x/", 12), repeat_char("../", 13)}, "", BY_PREDICTOR},
            '{"/a/b",              "",     BY_PREDICTOR}
        };

        foreach (dir_rows[r]) begin
            draft.delete();
            for (int i = 0; i < dir_rows[r].text.len(); i++) begin
                if (dir_rows[r].text[i] == "#")
                    draft.push_back(8'h00);
                else if (dir_rows[r].text[i] == "%")
                    draft.push_back(8'hFF);
                else
                    draft.push_back(byte_t'(dir_rows[r].text[i]));
            end
            queue_path(draft, r, r == dir_rows.size() - 1);
        end

        // random paths: mostly well-formed with random names, some with a
        // bad first byte, some raw byte noise after a leading slash
        rand_count = 0;
        mid_drain_done = 1'b0;
        while (rand_count < RAND_ITEMS) begin
            draft.delete();
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                draft.push_back(SLASH);
                ncomp = $urandom_range(0, 8);
                for (int c = 0; c < ncomp; c++) begin
                    if (c > 0) begin
                        draft.push_back(SLASH);
                        if ($urandom_range(0, 99) < 15)
                            draft.push_back(SLASH);
                    end
                    pick = $urandom_range(0, 99);
                    if (pick < 35) begin
                        len = $urandom_range(1, 6);
                        repeat (len) draft.push_back(name_byte());
                    end
                    else if (pick < 55) begin
                        draft.push_back(DOT);
                        draft.push_back(DOT);
                    end
                    else if (pick < 68)
                        draft.push_back(DOT);
                    else if (pick < 76) begin
                        len = $urandom_range(3, 5);
                        repeat (len) draft.push_back(DOT);
                    end
                    else if (pick < 88) begin
                        // names that start or end with a dot
                        if ($urandom_range(0, 1) == 0) begin
                            draft.push_back(DOT);
                            draft.push_back(name_byte());
                        end
                        else begin
                            draft.push_back(name_byte());
                            draft.push_back(DOT);
                        end
                    end
                    else if (pick < 94)
                        draft.push_back(SLASH);
                    else begin
                        len = $urandom_range(15, 40);
                        repeat (len) draft.push_back(name_byte());
                    end
                end
                if ($urandom_range(0, 99) < 30)
                    draft.push_back(SLASH);
            end
            else if (pick < 90) begin
                draft.push_back(name_byte());
                len = $urandom_range(0, 10);
                repeat (len) draft.push_back(byte_t'($urandom_range(0, 255)));
            end
            else begin
                draft.push_back(SLASH);
                len = $urandom_range(1, 20);
                repeat (len) draft.push_back(byte_t'($urandom_range(0, 255)));
            end
            rand_count += draft.size();
            queue_path(draft, -1, !mid_drain_done && rand_count >= RAND_ITEMS / 2);
            if (rand_count >= RAND_ITEMS / 2)
                mid_drain_done = 1'b1;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idx = 0;
        while (idx < path_items.size()) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && idx < path_items.size()) begin
                path_if.valid <= 1'b1;
                path_if.ch    <= path_items[idx].ch;
                path_if.last  <= path_items[idx].last;
                do @(posedge clk); while (path_if.ready !== 1'b1);
                burst--;
                idx++;
                if (path_items[idx - 1].drain_after) begin
                    path_if.valid <= 1'b0;
                    do @(posedge clk); while (due_bytes.size() != 0);
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                path_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        path_if.valid <= 1'b0;

        // everything sent: let the results drain, then watch for strays
        do @(posedge clk); while (due_bytes.size() != 0);
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result receiver: stretches of open, coin-flip, sparse and beat-pattern
    // ready, plus one long hold-off so the readout backs up into the input.
    // ------------------------------------------------------------------------
    initial begin : clean_receiver
        rx_mode_t mode;
        int       seg;
        int       span;
        clean_if.ready <= 1'b0;
        seg = 0;
        forever begin
            if (seg == 4) begin
                mode = RX_HOLD;
                span = 300;
            end
            else begin
                mode = rx_mode_t'($urandom_range(0, 3));
                span = $urandom_range(8, 60);
            end
            for (int n = 0; n < span; n++) begin
                case (mode)
                    RX_OPEN:   clean_if.ready <= 1'b1;
                    RX_COIN:   clean_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: clean_if.ready <= ($urandom_range(0, 3) == 0);
                    RX_BEAT:   clean_if.ready <= n[1];
                    default:   clean_if.ready <= 1'b0;
                endcase
                @(posedge clk);
            end
            seg++;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result item against the oldest expected byte, and
    // runs every accepted input item through the local model. Expected bytes
    // for a path are queued when its last item is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        clean_item_t got;
        clean_item_t want;
        int          row;
        if (rst_n) begin
            if (clean_if.valid === 1'b1 && clean_if.ready === 1'b1) begin
                got = '{clean_if.out_ch, clean_if.out_last, clean_if.error};
                if (due_bytes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected: ch=%h last=%b err=%b",
                             $time, got.ch, got.last, got.err);
                end
                else begin
                    want = due_bytes.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        $display("%0t: mismatch: expected ch=%h last=%b err=%b, got ch=%h last=%b err=%b",
                                 $time, want.ch, want.last, want.err,
                                 got.ch, got.last, got.err);
                    end
                end
            end

            if (path_if.valid === 1'b1 && path_if.ready === 1'b1) begin
                row = path_items[accept_idx].row;
                accept_idx++;
                norm_step(path_if.ch, path_if.last);
                if (path_if.last) begin
                    // literal rows override the model; the model still ran
                    // so its run state is cleared the same way
                    if (row >= 0 && dir_rows[row].kind == LITERAL_ERROR)
                        due_bytes.push_back('{8'h00, 1'b1, 1'b1});
                    else if (row >= 0 && dir_rows[row].kind == LITERAL_PATH) begin
                        for (int k = 0; k < dir_rows[row].want.len(); k++)
                            due_bytes.push_back('{byte_t'(dir_rows[row].want[k]),
                                                  (k == dir_rows[row].want.len() - 1),
                                                  1'b0});
                    end
                    else
                        foreach (norm_result[k])
                            due_bytes.push_back(norm_result[k]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends a hung run when no item moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (path_if.valid === 1'b1 && path_if.ready === 1'b1)
                   || (clean_if.valid === 1'b1 && clean_if.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG);
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
